>>> design/itmr_pkg.sv
// Package for the three-way interval timer: item layouts, mode and timer codes.
// No dependencies; used by the top level of the block and by its checker.
`default_nettype none

package itmr_pkg;

  // Width of every time field on the ports.
  localparam int unsigned FieldW = 48;

  typedef logic [FieldW-1:0] field_t;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_CHARGE = 3'd1,
    MODE_WRITE  = 3'd2,
    MODE_READ   = 3'd3,
    MODE_CANCEL = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    TMR_REAL    = 2'd0,
    TMR_VIRTUAL = 2'd1,
    TMR_PROFILE = 2'd2
  } timer_e;

  localparam int unsigned NumTimers = 3;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] which_timer;
    field_t     tick_delta;
    field_t     user_time;
    field_t     system_time;
    field_t     new_interval;
    field_t     new_value;
    logic       write_interval;
    logic       write_value;
  } in_item_t;

  typedef struct packed {
    field_t old_interval;
    field_t old_value;
    logic   real_alarm;
    logic   virtual_alarm;
    logic   profile_alarm;
  } out_item_t;

endpackage

`default_nettype wire

>>> design/itmr_charge.sv
// One timer's charge unit: subtract with clamp at zero, expire and reload.
// Depends on nothing but its TIME_WIDTH parameter.
`default_nettype none

module itmr_charge #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  wire logic [TIME_WIDTH-1:0] count_i,
  input  wire logic [TIME_WIDTH-1:0] reload_i,
  input  wire logic                  armed_i,
  input  wire logic [TIME_WIDTH-1:0] amount_i,
  output logic      [TIME_WIDTH-1:0] count_o,
  output logic                       armed_o,
  output logic                       expired_o
);

  logic [TIME_WIDTH-1:0] left;

  always_comb begin
    left = (count_i > amount_i) ? (count_i - amount_i) : '0;
    expired_o = armed_i && (left == '0);
    // reload on expiry, stay armed only with a nonzero interval
    if (expired_o) begin
      count_o = reload_i;
      armed_o = (reload_i != '0);
    end else begin
      count_o = left;
      armed_o = armed_i;
    end
  end

endmodule

`default_nettype wire

>>> design/three_way_interval_timer.sv
// Three reloading countdown timers (real, virtual, profile).
// Each result is registered and shown the cycle after its item's transfer.
// Throughput: one item per cycle while the output is not stalled; the timer state updates in the transfer cycle.
// Input ready drops only while a result waits and the output is stalled.
// Reset (async, active low) zeroes all intervals and values and disarms all timers.
`default_nettype none

module three_way_interval_timer
  import itmr_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  typedef logic [TIME_WIDTH-1:0] time_t;

  time_t     count_q  [NumTimers];
  time_t     count_d  [NumTimers];
  time_t     reload_q [NumTimers];
  time_t     reload_d [NumTimers];
  logic [NumTimers-1:0] armed_q, armed_d;

  logic      out_valid_q;
  out_item_t out_data_q, res;
  logic      xfer;

  time_t delta, user, sys, nint, nval, sum;
  logic [TIME_WIDTH:0] sum_wide;

  time_t virt_count, prof_count;
  logic  virt_armed, prof_armed, virt_exp, prof_exp;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign xfer        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign delta = time_t'(in_data_i.tick_delta);
  assign user  = time_t'(in_data_i.user_time);
  assign sys   = time_t'(in_data_i.system_time);
  assign nint  = time_t'(in_data_i.new_interval);
  assign nval  = time_t'(in_data_i.new_value);

  // saturate user plus system time
  assign sum_wide = {1'b0, user} + {1'b0, sys};
  assign sum      = sum_wide[TIME_WIDTH] ? '1 : sum_wide[TIME_WIDTH-1:0];

  itmr_charge #(.TIME_WIDTH(TIME_WIDTH)) u_virt (
    .count_i   (count_q[TMR_VIRTUAL]),
    .reload_i  (reload_q[TMR_VIRTUAL]),
    .armed_i   (armed_q[TMR_VIRTUAL]),
    .amount_i  (user),
    .count_o   (virt_count),
    .armed_o   (virt_armed),
    .expired_o (virt_exp)
  );

  itmr_charge #(.TIME_WIDTH(TIME_WIDTH)) u_prof (
    .count_i   (count_q[TMR_PROFILE]),
    .reload_i  (reload_q[TMR_PROFILE]),
    .armed_i   (armed_q[TMR_PROFILE]),
    .amount_i  (sum),
    .count_o   (prof_count),
    .armed_o   (prof_armed),
    .expired_o (prof_exp)
  );

  always_comb begin
    count_d  = count_q;
    reload_d = reload_q;
    armed_d  = armed_q;
    res      = '0;
    unique case (mode_e'(in_data_i.mode))
      MODE_TICK: begin
        if (armed_q[TMR_REAL]) begin
          if (count_q[TMR_REAL] < delta) begin
            count_d[TMR_REAL] = reload_q[TMR_REAL];
            armed_d[TMR_REAL] = (reload_q[TMR_REAL] != '0);
            res.real_alarm    = 1'b1;
          end else begin
            count_d[TMR_REAL] = count_q[TMR_REAL] - delta;
          end
        end
      end
      MODE_CHARGE: begin
        count_d[TMR_VIRTUAL] = virt_count;
        armed_d[TMR_VIRTUAL] = virt_armed;
        count_d[TMR_PROFILE] = prof_count;
        armed_d[TMR_PROFILE] = prof_armed;
        res.virtual_alarm    = virt_exp;
        res.profile_alarm    = prof_exp;
      end
      MODE_WRITE, MODE_READ: begin
        for (int unsigned t = 0; t < NumTimers; t++) begin
          if (in_data_i.which_timer == 2'(t)) begin
            res.old_interval = field_t'(reload_q[t]);
            res.old_value    = field_t'(count_q[t]);
            if (mode_e'(in_data_i.mode) == MODE_WRITE) begin
              if (in_data_i.write_interval) begin
                reload_d[t] = nint;
              end
              if (in_data_i.write_value) begin
                count_d[t] = nval;
                armed_d[t] = (nval != '0);
              end
            end
          end
        end
      end
      MODE_CANCEL: begin
        for (int unsigned t = 0; t < NumTimers; t++) begin
          count_d[t]  = '0;
          reload_d[t] = '0;
        end
        armed_d = '0;
      end
      default: begin
        // unused modes leave state alone
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned t = 0; t < NumTimers; t++) begin
        count_q[t]  <= '0;
        reload_q[t] <= '0;
      end
      armed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (xfer) begin
        count_q  <= count_d;
        reload_q <= reload_d;
        armed_q  <= armed_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      out_data_q <= res;
    end
  end

endmodule

`default_nettype wire

>>> design/itmr_checker.sv
// Port-level checker for the three-way interval timer, bound to the top level.
// Depends on itmr_pkg for the item layouts and mode codes.
`default_nettype none

module itmr_checker
  import itmr_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_item_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // every input transfer shows a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("no result after input transfer");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a read never raises an alarm
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_data_i.mode == MODE_READ) |=>
      !out_data_o.real_alarm && !out_data_o.virtual_alarm && !out_data_o.profile_alarm)
    else $error("alarm on read");

  // a read right after a cancel sees a cleared timer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (in_data_i.mode == MODE_CANCEL)) ##1 (in_xfer && (in_data_i.mode == MODE_READ))
      |=> (out_data_o.old_interval == '0) && (out_data_o.old_value == '0))
    else $error("timer not cleared by cancel");

endmodule

bind three_way_interval_timer itmr_checker u_itmr_checker (.*);

`default_nettype wire
